FILE: hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache table: field widths, operation
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } lfu_state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic update;
  } lfu_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic scan_last;
    logic out_free;
  } lfu_stat_t;

endpackage

FILE: hw/rtl/lfu_ifs.sv
// ----------------------------------------------------------------------------
// lfu channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfu_req_if import lfu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [KEY_W-1:0]  key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [DATA_W-1:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

interface lfu_cfg_if import lfu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

FILE: hw/rtl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key/value table with least-frequently-used replacement, oldest-first tie.
// Each request is accepted in idle, then the filled entries are scanned, one
// entry read per scan cycle, then a drain state and the update, which waits
// for the response register to be free and registers the response (the scan
// is skipped when the table is empty). A new request waits for the last one.
// Reset: synchronous; clears fill count, access clock, capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table import lfu_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int COUNT_W = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lfu_req_if.sink   in_req,
  lfu_rsp_if.source out_rsp,
  lfu_cfg_if.sink   cfg_wr
);

  lfu_cmd_t          cmd;
  lfu_stat_t         stat;
  logic              in_ready;
  logic              rsp_valid;
  logic              rsp_found;
  logic [DATA_W-1:0] rsp_value;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  lfu_dpath #(
    .ENTRIES (ENTRIES),
    .COUNT_W (COUNT_W)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_op          (in_req.op),
    .in_key         (in_req.key),
    .in_value       (in_req.value),
    .cfg_we         (cfg_wr.valid),
    .cfg_capacity   (cfg_wr.capacity),
    .out_valid      (rsp_valid),
    .out_ready      (out_rsp.ready),
    .out_found      (rsp_found),
    .out_read_value (rsp_value)
  );

  assign in_req.ready       = in_ready;
  assign cfg_wr.ready       = 1'b1;
  assign out_rsp.valid      = rsp_valid;
  assign out_rsp.found      = rsp_found;
  assign out_rsp.read_value = rsp_value;

endmodule

FILE: hw/rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer of the LFU cache table: accepts one request, steps the entry
// scan, and issues the table update once the response register is free.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lfu_stat_t stat_i,
  output lfu_cmd_t  cmd_o
);

  lfu_state_t state_r;
  lfu_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat_i.occ_zero ? ST_UPDATE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat_i.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd_o        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd_o.accept = in_valid;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_UPDATE: begin
        cmd_o.update = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lfu_dpath.sv
// ----------------------------------------------------------------------------
// lfu_dpath
// Datapath of the LFU cache table: entry memories, scan compare for key hit
// and replacement victim, fill count, access clock and response register.
// ----------------------------------------------------------------------------
module lfu_dpath import lfu_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int COUNT_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfu_cmd_t          cmd_i,
  output lfu_stat_t         stat_o,
  input  logic              in_op,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_value,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_capacity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [DATA_W-1:0] out_read_value
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [DATA_W-1:0]  data_mem  [ENTRIES];
  logic [COUNT_W-1:0] cnt_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  logic               op_r;
  logic [KEY_W-1:0]   key_r;
  logic [DATA_W-1:0]  val_r;
  logic [CAP_W-1:0]   cap_r;
  logic [OCC_W-1:0]   occ_r;
  logic [STAMP_W-1:0] clock_r;
  logic [IDX_W-1:0]   scan_idx_r;

  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic [DATA_W-1:0]  rd_data_r;
  logic [COUNT_W-1:0] rd_cnt_r;
  logic [STAMP_W-1:0] rd_stamp_r;

  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [DATA_W-1:0]  hit_data_r;
  logic [COUNT_W-1:0] hit_cnt_r;
  logic               vic_vld_r;
  logic [IDX_W-1:0]   vic_idx_r;
  logic [COUNT_W-1:0] vic_cnt_r;
  logic [STAMP_W-1:0] vic_age_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [DATA_W-1:0]  out_value_r;

  logic [STAMP_W-1:0] age;
  logic               is_match;
  logic               is_better;
  logic               is_put;
  logic               cap_zero;
  logic               room;
  logic               do_touch;
  logic               do_new;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [DATA_W-1:0]  wr_data;
  logic [COUNT_W-1:0] wr_cnt;
  logic [COUNT_W-1:0] hit_cnt_inc;

  assign stat_o.occ_zero  = (occ_r == '0);
  assign stat_o.scan_last = ((OCC_W'(scan_idx_r) + OCC_W'(1)) == occ_r);
  assign stat_o.out_free  = !out_valid_r || out_ready;

  assign age       = clock_r - rd_stamp_r;
  assign is_match  = cmp_vld_r && !hit_r && (rd_key_r == key_r);
  assign is_better = !vic_vld_r || (rd_cnt_r < vic_cnt_r) ||
                     ((rd_cnt_r == vic_cnt_r) && (age > vic_age_r));

  assign is_put      = (op_r == OP_PUT);
  assign cap_zero    = (cap_r == '0);
  assign room        = (CMP_W'(occ_r) < CMP_W'(cap_r)) && (occ_r < OCC_W'(ENTRIES));
  assign do_touch    = hit_r && (!is_put || !cap_zero);
  assign do_new      = is_put && !cap_zero && !hit_r && (room || vic_vld_r);
  assign mem_we      = cmd_i.update && (do_touch || do_new);
  assign hit_cnt_inc = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + COUNT_W'(1);

  always_comb begin
    if (hit_r) begin
      wr_idx = hit_idx_r;
    end else if (room) begin
      wr_idx = occ_r[IDX_W-1:0];
    end else begin
      wr_idx = vic_idx_r;
    end
  end

  assign wr_data = is_put ? val_r : hit_data_r;
  assign wr_cnt  = hit_r ? hit_cnt_inc : COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_idx]   <= key_r;
      data_mem[wr_idx]  <= wr_data;
      cnt_mem[wr_idx]   <= wr_cnt;
      stamp_mem[wr_idx] <= clock_r;
    end
    if (cmd_i.scan) begin
      rd_key_r   <= key_mem[scan_idx_r];
      rd_data_r  <= data_mem[scan_idx_r];
      rd_cnt_r   <= cnt_mem[scan_idx_r];
      rd_stamp_r <= stamp_mem[scan_idx_r];
      cmp_idx_r  <= scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd_i.accept) begin
      scan_idx_r <= '0;
    end else if (cmd_i.scan) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    if (is_match) begin
      hit_idx_r  <= cmp_idx_r;
      hit_data_r <= rd_data_r;
      hit_cnt_r  <= rd_cnt_r;
    end
    if (cmp_vld_r && is_better) begin
      vic_idx_r <= cmp_idx_r;
      vic_cnt_r <= rd_cnt_r;
      vic_age_r <= age;
    end
    if (cmd_i.update) begin
      out_found_r <= do_touch;
      out_value_r <= (!is_put && hit_r) ? hit_data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      clock_r     <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      vic_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
      cmp_vld_r <= cmd_i.scan;
      if (cmd_i.accept) begin
        hit_r     <= 1'b0;
        vic_vld_r <= 1'b0;
      end else begin
        if (is_match) begin
          hit_r <= 1'b1;
        end
        if (cmp_vld_r) begin
          vic_vld_r <= 1'b1;
        end
      end
      if (mem_we) begin
        clock_r <= clock_r + STAMP_W'(1);
      end
      if (cmd_i.update && do_new && room) begin
        occ_r <= occ_r + OCC_W'(1);
      end
      if (cmd_i.update) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;

`ifndef SYNTHESIS
  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(ENTRIES))
    else $error("fill count above table size");

  a_update_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.update |-> (!out_valid_r || out_ready))
    else $error("update while response register is occupied");

  a_occ_hold : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd_i.update)) |-> $stable(occ_r))
    else $error("fill count moved without an update");

  a_scan_range : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.scan |-> (OCC_W'(scan_idx_r) < occ_r))
    else $error("scan beyond filled entries");
`endif

endmodule

FILE: bench/tb_lfu_cache_table.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_table
// Self-checking bench for the LFU cache table. A scoreboard class keeps its
// own copy of the table, counts, stamps and capacity. It predicts the reply
// of every accepted request and checks replies in order. The stimulus runs a
// directed part, which covers count ordering, zero and oversized capacity
// and the field extremes. It then runs random phases at several capacities,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_lfu_cache_table;
  import lfu_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int HITS_W        = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int KEY_POOL      = 20;

  typedef struct {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
  } lfu_reply_t;

  class lfu_replacement_predictor;
    bit                 slot_valid [TABLE_DEPTH];
    logic [KEY_W-1:0]   slot_key   [TABLE_DEPTH];
    logic [DATA_W-1:0]  slot_data  [TABLE_DEPTH];
    logic [HITS_W-1:0]  slot_hits  [TABLE_DEPTH];
    logic [STAMP_W-1:0] slot_stamp [TABLE_DEPTH];
    logic [STAMP_W-1:0] tick;
    int                 filled;
    logic [CAP_W-1:0]   capacity;
    lfu_reply_t         expected_replies [$];
    int                 mismatches;

    function new();
      tick       = '0;
      filled     = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function void touch_slot(int i);
      if (slot_hits[i] != '1) slot_hits[i] = slot_hits[i] + 1'b1;
      slot_stamp[i] = tick;
      tick          = tick + 1'b1;
    endfunction

    function int lookup(logic [KEY_W-1:0] k);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_valid[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    function int choose_victim();
      int                 best;
      logic [HITS_W-1:0]  best_hits;
      logic [STAMP_W-1:0] best_age;
      logic [STAMP_W-1:0] age;
      best      = -1;
      best_hits = '0;
      best_age  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_valid[i]) begin
          age = tick - slot_stamp[i];
          if (best < 0 || slot_hits[i] < best_hits ||
              (slot_hits[i] == best_hits && age > best_age)) begin
            best      = i;
            best_hits = slot_hits[i];
            best_age  = age;
          end
        end
      end
      return best;
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
      int         hit;
      int         slot;
      int         limit;
      lfu_reply_t r;
      limit        = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity);
      hit          = lookup(k);
      r.found      = 1'b0;
      r.read_value = '0;
      if (op == OP_GET) begin
        if (hit >= 0) begin
          r.found      = 1'b1;
          r.read_value = slot_data[hit];
          touch_slot(hit);
        end
      end else if (limit != 0) begin
        if (hit >= 0) begin
          r.found        = 1'b1;
          slot_data[hit] = v;
          touch_slot(hit);
        end else begin
          slot = -1;
          if (filled < limit) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (!slot_valid[i]) begin
                slot = i;
                break;
              end
            end
            if (slot >= 0) filled++;
          end
          if (slot < 0) slot = choose_victim();
          if (slot >= 0) begin
            slot_valid[slot] = 1'b1;
            slot_key[slot]   = k;
            slot_data[slot]  = v;
            slot_hits[slot]  = HITS_W'(1);
            slot_stamp[slot] = tick;
            tick             = tick + 1'b1;
          end
        end
      end
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void check_response(logic found, logic signed [DATA_W-1:0] read_value);
      lfu_reply_t r;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual found=%0b read_value=%08h",
                 $time, found, read_value);
        mismatches++;
      end else begin
        r = expected_replies[0];
        expected_replies.delete(0);
        if (found !== r.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b", $time, r.found, found);
          mismatches++;
        end
        if (read_value !== r.read_value) begin
          $display("%0t: read_value mismatch, expected %08h, actual %08h",
                   $time, r.read_value, read_value);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;

  lfu_req_if req_if ();
  lfu_rsp_if rsp_if ();
  lfu_cfg_if cfg_if ();

  lfu_replacement_predictor table_model;

  lfu_cache_table #(
    .ENTRIES (TABLE_DEPTH),
    .COUNT_W (HITS_W)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_rsp (rsp_if.source),
    .cfg_wr  (cfg_if.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready)
        table_model.check_response(rsp_if.found, rsp_if.read_value);
      if (req_if.valid && req_if.ready)
        table_model.note_request(req_if.op, req_if.key, req_if.value);
      if (cfg_if.valid && cfg_if.ready)
        table_model.set_capacity(cfg_if.capacity);
    end
  end

  task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                              input logic [DATA_W-1:0] v);
    while (!steady && $urandom_range(99) < 25) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.key   <= k;
    req_if.value <= v;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic settle_table();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (table_model.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    settle_table();
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= c;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] c, input int count);
    logic [KEY_W-1:0] pool [KEY_POOL];
    logic [KEY_W-1:0] k;
    logic             op;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    write_capacity(c);
    repeat (count) begin
      k  = ($urandom_range(99) < 85) ? pool[$urandom_range(KEY_POOL-1)] : $urandom;
      op = $urandom_range(1) ? OP_PUT : OP_GET;
      send_request(op, k, $urandom);
    end
  endtask

  initial begin
    steady      = 1'b0;
    table_model = new();
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.op       <= OP_GET;
    req_if.key      <= '0;
    req_if.value    <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.capacity <= CAP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);

    // raise the hit count of one entry, then show it outlives a count of two
    write_capacity(5'd1);
    send_request(OP_PUT, 32'h5a5a_5a5a, 32'h0bad_cafe);
    steady = 1'b1;
    repeat (20) send_request(OP_GET, 32'h5a5a_5a5a, $urandom);
    steady = 1'b0;
    write_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_00b0, 32'h0000_0001);
    send_request(OP_GET, 32'h0000_00b0, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_00c0, 32'h0000_0002);
    send_request(OP_GET, 32'h5a5a_5a5a, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_00b0, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_00c0, 32'h0000_0000);

    // zero capacity: puts are dropped, gets still hit
    write_capacity(5'd0);
    send_request(OP_PUT, 32'h5a5a_5a5a, 32'h1111_1111);
    send_request(OP_GET, 32'h5a5a_5a5a, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_00d0, 32'h2222_2222);
    send_request(OP_GET, 32'h0000_00d0, 32'h0000_0000);

    // oversized capacity saturates to the table depth
    write_capacity(5'd31);
    send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_GET, 32'hffff_ffff, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h7fff_ffff, 32'h0000_0000);
    send_request(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_request(OP_GET, 32'h1234_5678, 32'h0000_0000);

    run_random_phase(5'd16, 220);
    run_random_phase(5'd5, 220);
    steady = 1'b1;
    run_random_phase(5'd1, 220);
    steady = 1'b0;
    run_random_phase(5'd31, 220);
    run_random_phase(5'd0, 60);
    run_random_phase(5'($urandom_range(15, 2)), 220);
    run_random_phase(5'd2, 220);
    run_random_phase(5'd16, 330);

    settle_table();
    if (table_model.mismatches == 0 && table_model.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: lfu_cache_table.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_ifs.sv
hw/rtl/lfu_ctrl.sv
hw/rtl/lfu_dpath.sv
hw/rtl/lfu_cache_table.sv
bench/tb_lfu_cache_table.sv
